/* rtl/core/decision_tree_classifier_top_defines.svh */
// Assertion macros shared by the decision tree classifier RTL.
// Depends on nothing; define ASSERT_OFF to compile the checks away.
`ifndef DECISION_TREE_CLASSIFIER_TOP_DEFINES_SVH
`define DECISION_TREE_CLASSIFIER_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define DTC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("dtc assertion failed");
`define DTC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("dtc assertion failed");
`else
`define DTC_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define DTC_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* rtl/core/dtc_pkg.sv */
// Types and constants for the decision tree classifier.
// Used by dtc_node_mem and decision_tree_classifier_top; depends on nothing.
package dtc_pkg;

  localparam int NODES     = 64;
  localparam int MAX_DEPTH = 64;
  localparam int ADDR_W    = $clog2(NODES);
  localparam int LVL_W     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  localparam logic OP_LOAD     = 1'b0;
  localparam logic OP_CLASSIFY = 1'b1;

  localparam logic [3:0] CODE_LEAF_NO  = 4'd0;
  localparam logic [3:0] CODE_PCLASS   = 4'd1;
  localparam logic [3:0] CODE_SEX      = 4'd2;
  localparam logic [3:0] CODE_AGE      = 4'd3;
  localparam logic [3:0] CODE_SIBLINGS = 4'd4;
  localparam logic [3:0] CODE_PARENTS  = 4'd5;
  localparam logic [3:0] CODE_FARE     = 4'd6;
  localparam logic [3:0] CODE_LEAF_YES = 4'd7;
  localparam logic [3:0] CODE_BAD_MIN  = 4'd8;

  localparam logic [2:0] STAT_WRITTEN   = 3'd0;
  localparam logic [2:0] STAT_PREDICTED = 3'd1;
  localparam logic [2:0] STAT_UNDECIDED = 3'd2;
  localparam logic [2:0] STAT_INVALID   = 3'd3;
  localparam logic [2:0] STAT_DEPTH     = 3'd4;

  localparam logic [8:0] CONF_MAX = 9'd256;

  typedef struct packed {
    logic [3:0]         code;
    logic signed [23:0] value;
    logic [6:0]         left;
    logic [6:0]         right;
  } node_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DONE
  } state_t;

endpackage

/* rtl/core/dtc_node_mem.sv */
// Node table of the decision tree classifier: one write port, one read port
// with a registered read. Depends on dtc_pkg.
module dtc_node_mem (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [dtc_pkg::ADDR_W-1:0] wr_addr,
  input  dtc_pkg::node_t             wr_data,
  input  logic                       rd_en,
  input  logic [dtc_pkg::ADDR_W-1:0] rd_addr,
  output dtc_pkg::node_t             rd_data
);
  import dtc_pkg::*;

  node_t mem [NODES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/core/decision_tree_classifier_top.sv */
// Decision tree classifier top level: control, record registers, output register.
// Depends on dtc_pkg, dtc_node_mem and decision_tree_classifier_top_defines.svh.
//
// This block walks a binary decision tree held in a 64-entry node memory. A
// load transaction (op 0) writes one node and answers at once with status 0.
// A classify transaction (op 1) starts at the node named by the root register
// and reads one node per cycle from the node memory; a walk visits at most 64
// nodes, the depth limit. The node memory read and the threshold compare form
// the loop that sets this rate. Only one transaction is in flight at a time,
// but a finished result sits in an output register, so the next transaction
// is taken while the previous result waits to be read.
// The root register may only be written while the block is idle. Nodes that
// were never written hold unknown contents and must not be reached by a walk.
`include "decision_tree_classifier_top_defines.svh"
module decision_tree_classifier_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic [5:0]         cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_op,
  input  logic [5:0]         in_node_index,
  input  logic [3:0]         in_node_code,
  input  logic signed [23:0] in_node_value,
  input  logic [6:0]         in_left_child,
  input  logic [6:0]         in_right_child,
  input  logic [7:0]         in_pclass,
  input  logic               in_sex,
  input  logic [7:0]         in_age,
  input  logic [7:0]         in_siblings,
  input  logic [7:0]         in_parents,
  input  logic [22:0]        in_fare,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_status,
  output logic               out_survives,
  output logic [8:0]         out_confidence
);
  import dtc_pkg::*;

  // Control state.
  state_t             state_r, state_nxt;
  logic [5:0]         root_r;
  logic [LVL_W-1:0]   lvl_r, lvl_nxt;
  logic               out_valid_r;

  // Record attributes held for the length of a walk.
  logic [7:0]         rec_pclass_r, rec_age_r, rec_siblings_r, rec_parents_r;
  logic               rec_sex_r;
  logic [22:0]        rec_fare_r;

  // Result waiting for the output register, and the output register itself.
  logic [2:0]         res_status_r, res_status_nxt;
  logic               res_surv_r, res_surv_nxt;
  logic [8:0]         res_conf_r, res_conf_nxt;
  logic               res_ld;
  logic [2:0]         out_status_r;
  logic               out_surv_r;
  logic [8:0]         out_conf_r;

  // Node memory ports.
  logic               mem_wr_en, mem_rd_en;
  logic [ADDR_W-1:0]  mem_rd_addr;
  node_t              mem_wr_data, node;

  // Evaluation of the node just read.
  logic signed [24:0] attr_sel;
  logic               go_left, is_leaf, is_bad, child_ok, depth_hit, eval_done;
  logic [6:0]         child;
  logic [2:0]         eval_status;
  logic [8:0]         eval_conf;

  logic               in_fire, out_free, root_ok;

  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign root_ok  = 32'(root_r) < NODES;

  assign mem_wr_en = in_fire && (in_op == OP_LOAD) && (32'(in_node_index) < NODES);
  assign mem_wr_data = '{code: in_node_code, value: in_node_value,
                         left: in_left_child, right: in_right_child};

  dtc_node_mem u_node_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (in_node_index[ADDR_W-1:0]),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (node)
  );

  // Pick the attribute named by the node. Integer attributes are scaled by
  // 256 to line up with the Q16.8 threshold; the compare is done in 25 bits.
  always_comb begin
    case (node.code)
      CODE_PCLASS:   attr_sel = {9'd0, rec_pclass_r, 8'd0};
      CODE_SEX:      attr_sel = {16'd0, rec_sex_r, 8'd0};
      CODE_AGE:      attr_sel = {9'd0, rec_age_r, 8'd0};
      CODE_SIBLINGS: attr_sel = {9'd0, rec_siblings_r, 8'd0};
      CODE_PARENTS:  attr_sel = {9'd0, rec_parents_r, 8'd0};
      CODE_FARE:     attr_sel = {2'd0, rec_fare_r};
      default:       attr_sel = '0;
    endcase
  end

  always_comb begin
    go_left   = attr_sel <= $signed({node.value[23], node.value});
    child     = go_left ? node.left : node.right;
    is_leaf   = (node.code == CODE_LEAF_NO) || (node.code == CODE_LEAF_YES);
    is_bad    = node.code >= CODE_BAD_MIN;
    child_ok  = 32'(child) < NODES;
    depth_hit = lvl_r == LVL_W'(MAX_DEPTH - 1);
    eval_done = is_leaf || is_bad || depth_hit || !child_ok;

    // Leaf confidence saturates to the range 0 to 256.
    if (node.value[23]) begin
      eval_conf = '0;
    end else if (node.value > $signed(24'(CONF_MAX))) begin
      eval_conf = CONF_MAX;
    end else begin
      eval_conf = node.value[8:0];
    end

    if (is_leaf) begin
      eval_status = STAT_PREDICTED;
    end else if (is_bad) begin
      eval_status = STAT_INVALID;
    end else if (depth_hit) begin
      eval_status = STAT_DEPTH;
    end else begin
      eval_status = STAT_UNDECIDED;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if ((in_op == OP_CLASSIFY) && root_ok) begin
            state_nxt = ST_EVAL;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_EVAL: begin
        if (eval_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State outputs: memory reads, level count and the pending result.
  always_comb begin
    in_ready       = 1'b0;
    mem_rd_en      = 1'b0;
    mem_rd_addr    = root_r[ADDR_W-1:0];
    lvl_nxt        = lvl_r;
    res_ld         = 1'b0;
    res_status_nxt = STAT_WRITTEN;
    res_surv_nxt   = 1'b0;
    res_conf_nxt   = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        lvl_nxt  = '0;
        if (in_valid) begin
          if (in_op == OP_LOAD) begin
            res_ld = 1'b1;
          end else if (root_ok) begin
            mem_rd_en = 1'b1;
          end else begin
            res_ld         = 1'b1;
            res_status_nxt = STAT_UNDECIDED;
          end
        end
      end
      ST_EVAL: begin
        mem_rd_addr = child[ADDR_W-1:0];
        if (eval_done) begin
          res_ld         = 1'b1;
          res_status_nxt = eval_status;
          if (is_leaf) begin
            res_surv_nxt = node.code == CODE_LEAF_YES;
            res_conf_nxt = eval_conf;
          end
        end else begin
          mem_rd_en = 1'b1;
          lvl_nxt   = lvl_r + 1'b1;
        end
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      root_r      <= '0;
      lvl_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      lvl_r   <= lvl_nxt;
      if (cfg_wr_en) begin
        root_r <= cfg_wr_data;
      end
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      rec_pclass_r   <= in_pclass;
      rec_sex_r      <= in_sex;
      rec_age_r      <= in_age;
      rec_siblings_r <= in_siblings;
      rec_parents_r  <= in_parents;
      rec_fare_r     <= in_fare;
    end
    if (res_ld) begin
      res_status_r <= res_status_nxt;
      res_surv_r   <= res_surv_nxt;
      res_conf_r   <= res_conf_nxt;
    end
    if (state_r == ST_DONE && out_free) begin
      out_status_r <= res_status_r;
      out_surv_r   <= res_surv_r;
      out_conf_r   <= res_conf_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_survives   = out_surv_r;
  assign out_confidence = out_conf_r;

  // A finished result is held back while the output register is occupied.
  `DTC_ASSERT_NXT(a_done_holds, clk, rst_n, state_r == ST_DONE && out_valid_r && !out_ready, state_r == ST_DONE)
  // Each further step of a walk reads exactly one more level.
  `DTC_ASSERT_NXT(a_level_step, clk, rst_n, state_r == ST_EVAL && state_nxt == ST_EVAL, lvl_r == $past(lvl_r) + 1'b1)
  // Only a prediction carries an outcome and a confidence.
  `DTC_ASSERT_IMP(a_no_pred_zero, clk, rst_n, out_valid_r && out_status_r != STAT_PREDICTED, !out_surv_r && out_conf_r == '0)
  // A walk never runs past the depth limit.
  `DTC_ASSERT_IMP(a_depth_stop, clk, rst_n, state_r == ST_EVAL && depth_hit, state_nxt == ST_DONE)

endmodule

/* sim/decision_tree_classifier_top_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for decision_tree_classifier_top: builds node tables,
// classifies records and checks every result against a predicted tree walk.
// Depends on dtc_pkg and the classifier RTL; reads no files.
module decision_tree_classifier_top_tb;
  import dtc_pkg::*;

  localparam int HALF_PERIOD  = 4;
  localparam int RESET_CYCLES = 11;
  // The longest quiet stretch of a correct run is the deliberate hold on the
  // result side, which outlasts any walk, so this limit is ample.
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 80;
  localparam int PHASE_ITEMS  = 100;
  localparam int HOLD_CYCLES  = 400;
  localparam int REPORT_MAX   = 10;

  localparam logic [3:0] CODE_BAD_MAX = 4'd15;
  localparam logic [6:0] NULL_CHILD   = 7'd64;
  localparam logic [6:0] NULL_TOP     = 7'd127;

  // One input transaction, field by field, at the widths of the ports.
  typedef struct {
    logic               op;
    logic [5:0]         node_index;
    logic [3:0]         node_code;
    logic signed [23:0] node_value;
    logic [6:0]         left_child;
    logic [6:0]         right_child;
    logic [7:0]         pclass;
    logic               sex;
    logic [7:0]         age;
    logic [7:0]         siblings;
    logic [7:0]         parents;
    logic [22:0]        fare;
  } tree_req_t;

  // One result transaction.
  typedef struct {
    logic [2:0] status;
    logic       survives;
    logic [8:0] confidence;
  } verdict_t;

  // The board keeps its own copy of the node table and the root register,
  // walks the tree for every accepted classify transaction and holds the
  // verdicts that are still owed by the block, oldest first.
  class verdict_board;
    logic [3:0] node_code [NODES];
    int         node_value [NODES];
    logic [6:0] node_left [NODES];
    logic [6:0] node_right [NODES];
    logic [5:0] root;
    verdict_t   pending [$];
    int         mismatches;

    function new();
      root = '0;
      mismatches = 0;
      foreach (node_code[i]) begin
        node_code[i]  = CODE_LEAF_NO;
        node_value[i] = 0;
        node_left[i]  = '0;
        node_right[i] = '0;
      end
    endfunction

    function verdict_t walk(tree_req_t r);
      int         attr [7];
      int         conf;
      logic [6:0] cur;
      verdict_t   v;
      v = '{STAT_DEPTH, 1'b0, 9'd0};
      // Integer attributes become Q16.8 by a shift of eight; fare already is.
      attr[0]             = 0;
      attr[CODE_PCLASS]   = int'(r.pclass) * 256;
      attr[CODE_SEX]      = int'(r.sex) * 256;
      attr[CODE_AGE]      = int'(r.age) * 256;
      attr[CODE_SIBLINGS] = int'(r.siblings) * 256;
      attr[CODE_PARENTS]  = int'(r.parents) * 256;
      attr[CODE_FARE]     = int'(r.fare);
      cur = {1'b0, root};
      for (int lvl = 0; lvl < MAX_DEPTH; lvl++) begin
        if (cur >= NODES) begin
          v.status = STAT_UNDECIDED;
          return v;
        end
        if (node_code[cur] == CODE_LEAF_NO || node_code[cur] == CODE_LEAF_YES) begin
          conf = node_value[cur];
          if (conf < 0)
            conf = 0;
          else if (conf > int'(CONF_MAX))
            conf = int'(CONF_MAX);
          v.status     = STAT_PREDICTED;
          v.survives   = (node_code[cur] == CODE_LEAF_YES);
          v.confidence = conf[8:0];
          return v;
        end
        if (node_code[cur] >= CODE_BAD_MIN) begin
          v.status = STAT_INVALID;
          return v;
        end
        cur = (attr[node_code[cur]] <= node_value[cur]) ? node_left[cur] : node_right[cur];
      end
      return v;
    endfunction

    function void log_request(tree_req_t r);
      verdict_t v;
      if (r.op == OP_LOAD) begin
        node_code[r.node_index]  = r.node_code;
        node_value[r.node_index] = $signed(r.node_value);
        node_left[r.node_index]  = r.left_child;
        node_right[r.node_index] = r.right_child;
        v = '{STAT_WRITTEN, 1'b0, 9'd0};
      end else begin
        v = walk(r);
      end
      pending.push_back(v);
    endfunction

    function void check_verdict(verdict_t got);
      verdict_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: unexpected result, status %0d survives %0d confidence %0d",
                   $time, got.status, got.survives, got.confidence);
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status || got.survives !== want.survives ||
          got.confidence !== want.confidence) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: expected status %0d survives %0d confidence %0d, got %0d %0d %0d",
                   $time, want.status, want.survives, want.confidence,
                   got.status, got.survives, got.confidence);
      end
    endfunction
  endclass

  verdict_board board = new();

  // Clock, reset and every input of the block start at known values.
  logic               clk            = 1'b0;
  logic               rst_n          = 1'b0;
  logic               cfg_wr_en      = 1'b0;
  logic [5:0]         cfg_wr_data    = '0;
  logic               in_valid       = 1'b0;
  logic               in_ready;
  logic               in_op          = 1'b0;
  logic [5:0]         in_node_index  = '0;
  logic [3:0]         in_node_code   = '0;
  logic signed [23:0] in_node_value  = '0;
  logic [6:0]         in_left_child  = '0;
  logic [6:0]         in_right_child = '0;
  logic [7:0]         in_pclass      = '0;
  logic               in_sex         = 1'b0;
  logic [7:0]         in_age         = '0;
  logic [7:0]         in_siblings    = '0;
  logic [7:0]         in_parents     = '0;
  logic [22:0]        in_fare        = '0;
  logic               out_valid;
  logic               out_ready      = 1'b0;
  logic [2:0]         out_status;
  logic               out_survives;
  logic [8:0]         out_confidence;

  // Traffic shaping, set by the stimulus for each phase. A nonzero hold request
  // makes the result side refuse results for a stretch as long as the request.
  int         sender_idle_pct = 0;
  int         stall_pct       = 0;
  int         hold_req        = 0;
  logic [5:0] cur_root        = '0;

  always #(HALF_PERIOD) clk = ~clk;

  decision_tree_classifier_top u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_node_index  (in_node_index),
    .in_node_code   (in_node_code),
    .in_node_value  (in_node_value),
    .in_left_child  (in_left_child),
    .in_right_child (in_right_child),
    .in_pclass      (in_pclass),
    .in_sex         (in_sex),
    .in_age         (in_age),
    .in_siblings    (in_siblings),
    .in_parents     (in_parents),
    .in_fare        (in_fare),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_survives   (out_survives),
    .out_confidence (out_confidence)
  );

  // Every field gets a random value, so that the fields an operation ignores
  // still toggle; callers then overwrite what matters for the case at hand.
  function automatic tree_req_t rand_req(logic op);
    tree_req_t r;
    r.op          = op;
    r.node_index  = 6'($urandom_range(0, NODES - 1));
    r.node_code   = 4'($urandom_range(0, CODE_BAD_MAX));
    r.node_value  = 24'($urandom);
    r.left_child  = 7'($urandom_range(0, NULL_TOP));
    r.right_child = 7'($urandom_range(0, NULL_TOP));
    r.pclass      = 8'($urandom);
    r.sex         = 1'($urandom);
    r.age         = 8'($urandom);
    r.siblings    = 8'($urandom);
    r.parents     = 8'($urandom);
    r.fare        = 23'($urandom);
    return r;
  endfunction

  // Child of a split at distance k from the root. Mostly a node a little
  // further down, which keeps walks acyclic and several levels deep. A few
  // children are null marks, and a few point back up the tree, which can
  // close a loop and run the walk into the depth limit.
  function automatic logic [6:0] pick_child(int k);
    int p;
    p = $urandom_range(0, 99);
    if (p < 4)
      return 7'($urandom_range(NULL_CHILD, NULL_TOP));
    if (p < 7)
      return 7'((int'(cur_root) + $urandom_range(0, k)) & (NODES - 1));
    return 7'((int'(cur_root) + k + 1 + $urandom_range(0, 4)) & (NODES - 1));
  endfunction

  // A load transaction for one node of a tree hanging from cur_root.
  function automatic tree_req_t make_node(int slot);
    tree_req_t r;
    int        k;
    int        pick;
    r = rand_req(OP_LOAD);
    k = (slot - int'(cur_root)) & (NODES - 1);
    r.node_index = 6'(slot);
    pick = $urandom_range(0, 99);
    if (k >= 48 || pick < 12) begin
      // Leaves: confidence mostly around the saturation points, rarely wild.
      r.node_code  = $urandom_range(0, 1) ? CODE_LEAF_YES : CODE_LEAF_NO;
      r.node_value = (pick < 3) ? 24'($urandom) : 24'($urandom_range(0, 600) - 150);
    end else if (pick < 15) begin
      r.node_code = 4'($urandom_range(CODE_BAD_MIN, CODE_BAD_MAX));
    end else begin
      r.node_code = 4'($urandom_range(CODE_PCLASS, CODE_FARE));
      case (r.node_code)
        CODE_SEX: begin
          // Thresholds of -1, 0, 255 and 256 sit on both sides of both values.
          pick = $urandom_range(0, 3);
          r.node_value = 24'((pick >> 1) * 256 + (pick & 1) - 1);
        end
        CODE_FARE: begin
          r.node_value = 24'($urandom_range(0, 23'h7FFFFF));
        end
        default: begin
          r.node_value = 24'($urandom_range(0, 255) * 256 + $urandom_range(0, 2) - 1);
        end
      endcase
      r.left_child  = pick_child(k);
      r.right_child = pick_child(k);
    end
    return r;
  endfunction

  // Offers one transaction on the input channel, with random idle cycles in
  // front of it, and hands it to the board at the edge where it is accepted.
  // Returns at the falling edge after acceptance with valid still high.
  task automatic send_item(input tree_req_t r);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_op          <= r.op;
    in_node_index  <= r.node_index;
    in_node_code   <= r.node_code;
    in_node_value  <= r.node_value;
    in_left_child  <= r.left_child;
    in_right_child <= r.right_child;
    in_pclass      <= r.pclass;
    in_sex         <= r.sex;
    in_age         <= r.age;
    in_siblings    <= r.siblings;
    in_parents     <= r.parents;
    in_fare        <= r.fare;
    in_valid       <= 1'b1;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    board.log_request(r);
    @(negedge clk);
  endtask

  task automatic load_node(input int idx, input logic [3:0] code, input int value,
                           input int lch, input int rch);
    tree_req_t r;
    r = rand_req(OP_LOAD);
    r.node_index  = 6'(idx);
    r.node_code   = code;
    r.node_value  = 24'(value);
    r.left_child  = 7'(lch);
    r.right_child = 7'(rch);
    send_item(r);
  endtask

  task automatic classify(input int pclass, input int sex, input int age,
                          input int siblings, input int parents, input int fare);
    tree_req_t r;
    r = rand_req(OP_CLASSIFY);
    r.pclass   = 8'(pclass);
    r.sex      = 1'(sex);
    r.age      = 8'(age);
    r.siblings = 8'(siblings);
    r.parents  = 8'(parents);
    r.fare     = 23'(fare);
    send_item(r);
  endtask

  // One phase: drain the block, write the root register while it is idle,
  // rebuild the whole table around the new root and then mostly classify,
  // with rewrites of single nodes and noise loads mixed in. With squeeze set
  // the result side holds off twice while the input keeps offering work.
  task automatic run_phase(input logic [5:0] root, input int send_idle, input int stall,
                           input bit squeeze);
    tree_req_t r;
    int        pick;
    in_valid <= 1'b0;
    while (board.pending.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= root;
    cur_root    = root;
    board.root  = root;
    @(negedge clk);
    cfg_wr_en       <= 1'b0;
    sender_idle_pct = send_idle;
    stall_pct       = stall;
    if (squeeze)
      hold_req = HOLD_CYCLES;
    for (int s = 0; s < NODES; s++)
      send_item(make_node(s));
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      if (squeeze && n == PHASE_ITEMS / 2)
        hold_req = HOLD_CYCLES;
      pick = $urandom_range(0, 99);
      if (pick < 80)
        r = rand_req(OP_CLASSIFY);
      else if (pick < 90)
        r = make_node($urandom_range(0, NODES - 1));
      else
        r = rand_req(OP_LOAD);
      send_item(r);
    end
  endtask

  // Result side: ready changes at the falling edge, either held low on request
  // or dropped at random according to the stall percentage of the phase.
  initial begin : result_sink
    int held;
    held = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        held     = hold_req;
        hold_req = 0;
      end
      if (held > 0) begin
        out_ready <= 1'b0;
        held--;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Results are sampled at the rising edge and checked at once. The same
  // process watches for a stretch with no transaction on either channel.
  initial begin : result_monitor
    int       quiet;
    verdict_t got;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        got.status     = out_status;
        got.survives   = out_survives;
        got.confidence = out_confidence;
        board.check_verdict(got);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part, with the root left at its reset value of node 0. Node 0
    // splits on sex; the rest of the small tree covers the field extremes,
    // both kinds of leaf, saturation, null children, invalid codes and a loop.
    load_node(0, CODE_SEX, 0, 1, 2);
    load_node(1, CODE_LEAF_NO, -8388608, 0, 0);      // negative confidence clips to 0
    load_node(2, CODE_FARE, 8388606, 3, NULL_CHILD);
    load_node(3, CODE_LEAF_YES, 8388607, 0, 0);      // large confidence clips to 256
    classify(0, 0, 0, 0, 0, 0);
    classify(255, 1, 255, 255, 255, 8388606);        // fare equal to threshold goes left
    classify(0, 1, 0, 0, 0, 8388607);                // right child is the null mark
    load_node(2, CODE_PCLASS, 65279, 4, NULL_TOP);
    load_node(4, CODE_BAD_MAX, 0, 0, 0);
    classify(255, 1, 0, 0, 0, 0);                    // null child above the usual mark
    classify(0, 1, 0, 0, 0, 0);                      // lands on an invalid code
    load_node(4, CODE_BAD_MIN, 0, 0, 0);
    classify(3, 1, 0, 0, 0, 0);
    load_node(4, CODE_AGE, 8388607, 4, 4);           // node points at itself
    classify(1, 1, 255, 0, 0, 0);                    // runs into the depth limit
    load_node(4, CODE_SIBLINGS, 768, 5, 6);
    load_node(5, CODE_LEAF_YES, 257, 0, 0);
    load_node(6, CODE_PARENTS, 256, 7, 5);
    load_node(7, CODE_LEAF_NO, 256, 0, 0);
    classify(1, 1, 0, 3, 0, 0);
    classify(1, 1, 0, 4, 1, 0);
    classify(1, 1, 0, 255, 255, 0);
    load_node(5, CODE_LEAF_YES, 128, 0, 0);
    classify(2, 1, 0, 0, 0, 0);

    // Random phases, each with a chosen root and traffic pattern.
    run_phase(6'd63, 0, 0, 1'b0);
    run_phase(6'($urandom_range(1, NODES - 2)), 86, 0, 1'b0);
    run_phase(6'd0, 0, 86, 1'b0);
    run_phase(6'($urandom_range(0, NODES - 1)), 21, 21, 1'b0);
    run_phase(6'd63, 0, 0, 1'b1);

    // Let the last results out, then watch a little longer for strays.
    in_valid <= 1'b0;
    while (board.pending.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
